>>> rtl/core/gse_pkg.sv
// ----------------------------------------------------------------------------
// GJK simplex evolve package
// Shared constants and types for the simplex evolve block.
// ----------------------------------------------------------------------------
package gse_pkg;

  localparam int unsigned DEF_COORD_BITS = 16;
  localparam int unsigned DIR_BITS       = 51;
  localparam int unsigned MAX_POINTS     = 4;
  localparam int unsigned CNT_BITS       = 3;

  localparam logic [1:0] MODE_ADD    = 2'd0;
  localparam logic [1:0] MODE_EVOLVE = 2'd1;
  localparam logic [1:0] MODE_CLEAR  = 2'd2;
  localparam logic [1:0] MODE_NOP    = 2'd3;

  localparam logic [CNT_BITS-1:0] CNT_LINE  = 3'd2;
  localparam logic [CNT_BITS-1:0] CNT_TRI   = 3'd3;
  localparam logic [CNT_BITS-1:0] CNT_TETRA = 3'd4;

  typedef enum logic [5:0] {
    ST_IDLE   = 6'b000001,
    ST_CROSS  = 6'b000010,
    ST_DOT    = 6'b000100,
    ST_DRAIN  = 6'b001000,
    ST_DECIDE = 6'b010000,
    ST_DONE   = 6'b100000
  } state_e;

  typedef struct packed {
    logic       vld;
    logic       neg;
    logic       first;
    logic       wr;
    logic [1:0] comp;
  } mac_tag_t;

endpackage

>>> rtl/core/gjk_simplex_evolve.sv
// ----------------------------------------------------------------------------
// GJK simplex evolve
// Holds a simplex of up to four points and evolves it toward the origin.
// ----------------------------------------------------------------------------
// The input channel takes one beat per command: add a point, evolve the
// simplex, clear it or do nothing. Every accepted beat yields exactly one
// output beat carrying the accept flag, the containment flag, the search
// direction and the point count after the command.
// Add, clear and the single point case pass through the done state to
// the output register. Evolve runs on one shared multiply-accumulate
// unit: each cross product takes 6 products and each dot product 3, and
// each phase ends in a drain and a decision state; a tetrahedron tests up
// to three faces.
// The input is ready only while no command is in progress, so one command
// is worked on at a time. A finished result waits in the output register
// while the next command is accepted; a stalled receiver holds the block in
// its final state until the output register frees up.
// Reset empties the simplex, zeroes all points and drops any pending output.
// ----------------------------------------------------------------------------
module gjk_simplex_evolve #(
  parameter int unsigned COORD_BITS = gse_pkg::DEF_COORD_BITS
) (
  input  logic                                  clk_i,
  input  logic                                  rst_ni,
  input  logic                                  in_valid_i,
  output logic                                  in_ready_o,
  input  logic [1:0]                            mode_i,
  input  logic signed [COORD_BITS-1:0]          point_x_i,
  input  logic signed [COORD_BITS-1:0]          point_y_i,
  input  logic signed [COORD_BITS-1:0]          point_z_i,
  output logic                                  out_valid_o,
  input  logic                                  out_ready_i,
  output logic                                  accepted_o,
  output logic                                  contains_origin_o,
  output logic signed [gse_pkg::DIR_BITS-1:0]   dir_x_o,
  output logic signed [gse_pkg::DIR_BITS-1:0]   dir_y_o,
  output logic signed [gse_pkg::DIR_BITS-1:0]   dir_z_o,
  output logic [gse_pkg::CNT_BITS-1:0]          point_count_o
);

  localparam int unsigned CW = COORD_BITS;
  localparam int unsigned DW = CW + 1;
  localparam int unsigned NW = 2 * CW + 3;
  localparam int unsigned PW = NW + DW;
  localparam int unsigned AW = PW + 2;

  gse_pkg::state_e state_q, state_d;

  logic signed [CW-1:0] pts_q [gse_pkg::MAX_POINTS][3];
  logic [gse_pkg::CNT_BITS-1:0] cnt_q;
  logic [2:0] step_q;
  logic [1:0] face_q;
  logic       pass_q;
  logic       phase_q;

  logic signed [AW-1:0] res_q [3];
  logic signed [NW-1:0] t_q [3];
  logic signed [AW-1:0] acc_q;
  logic signed [PW-1:0] prod_q;
  gse_pkg::mac_tag_t    tag_q, tag_d;

  logic p_acc_q, p_cont_q;

  logic                           out_valid_q;
  logic                           out_acc_q, out_cont_q;
  logic signed [gse_pkg::DIR_BITS-1:0] out_dir_q [3];
  logic [gse_pkg::CNT_BITS-1:0]   out_cnt_q;

  logic signed [DW-1:0] dif_p [3];
  logic signed [DW-1:0] dif_q [3];
  logic signed [DW-1:0] vec_r [3];
  logic signed [NW-1:0] wide_p [3];
  logic signed [NW-1:0] a_op;
  logic signed [DW-1:0] b_op;
  logic [1:0]           pi, qi;
  logic signed [AW-1:0] acc_sum, prod_ext;
  logic signed [CW-1:0] in_pt [3];

  logic in_fire, done_fire, dot_pos, dot_neg, t_zero;
  logic dec_cont, dec_flip, rep_en;
  logic [1:0] rep_idx;

  assign in_ready_o = (state_q == gse_pkg::ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign done_fire  = (state_q == gse_pkg::ST_DONE) && (!out_valid_q || out_ready_i);

  assign in_pt[0] = point_x_i;
  assign in_pt[1] = point_y_i;
  assign in_pt[2] = point_z_i;

  assign dot_pos = (acc_q > 0);
  assign dot_neg = (acc_q < 0);
  assign t_zero  = (res_q[0] == '0) && (res_q[1] == '0) && (res_q[2] == '0);

  // Operand vectors for the current simplex case.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      dif_p[i]  = '0;
      dif_q[i]  = '0;
      vec_r[i]  = '0;
      case (cnt_q)
        gse_pkg::CNT_TETRA: begin
          vec_r[i] = -DW'(pts_q[3][i]);
          case (face_q)
            2'd0: begin
              dif_p[i] = DW'(pts_q[3][i]) - DW'(pts_q[0][i]);
              dif_q[i] = DW'(pts_q[3][i]) - DW'(pts_q[1][i]);
            end
            2'd1: begin
              dif_p[i] = DW'(pts_q[3][i]) - DW'(pts_q[2][i]);
              dif_q[i] = DW'(pts_q[3][i]) - DW'(pts_q[0][i]);
            end
            default: begin
              dif_p[i] = DW'(pts_q[3][i]) - DW'(pts_q[1][i]);
              dif_q[i] = DW'(pts_q[3][i]) - DW'(pts_q[2][i]);
            end
          endcase
        end
        gse_pkg::CNT_TRI: begin
          vec_r[i] = -DW'(pts_q[0][i]);
          dif_p[i] = DW'(pts_q[2][i]) - DW'(pts_q[0][i]);
          dif_q[i] = DW'(pts_q[1][i]) - DW'(pts_q[0][i]);
        end
        gse_pkg::CNT_LINE: begin
          if (pass_q) begin
            dif_q[i] = DW'(pts_q[0][i]) - DW'(pts_q[1][i]);
          end else begin
            dif_p[i] = DW'(pts_q[0][i]) - DW'(pts_q[1][i]);
            dif_q[i] = -DW'(pts_q[1][i]);
          end
        end
        default: begin
        end
      endcase
      if ((cnt_q == gse_pkg::CNT_LINE) && pass_q) begin
        wide_p[i] = t_q[i];
      end else begin
        wide_p[i] = NW'(dif_p[i]);
      end
    end
  end

  // Cross product term order: y*z-z*y, z*x-x*z, x*y-y*x.
  always_comb begin
    case (step_q)
      3'd0: begin pi = 2'd1; qi = 2'd2; end
      3'd1: begin pi = 2'd2; qi = 2'd1; end
      3'd2: begin pi = 2'd2; qi = 2'd0; end
      3'd3: begin pi = 2'd0; qi = 2'd2; end
      3'd4: begin pi = 2'd0; qi = 2'd1; end
      3'd5: begin pi = 2'd1; qi = 2'd0; end
      default: begin pi = 2'd0; qi = 2'd0; end
    endcase
    tag_d = '0;
    if (state_q == gse_pkg::ST_DOT) begin
      a_op        = NW'(res_q[step_q[1:0]]);
      b_op        = vec_r[step_q[1:0]];
      tag_d.vld   = 1'b1;
      tag_d.first = (step_q == 3'd0);
    end else begin
      a_op        = wide_p[pi];
      b_op        = dif_q[qi];
      tag_d.vld   = (state_q == gse_pkg::ST_CROSS);
      tag_d.neg   = step_q[0];
      tag_d.first = !step_q[0];
      tag_d.wr    = step_q[0];
      tag_d.comp  = step_q[2:1];
    end
  end

  assign prod_ext = AW'(prod_q);
  assign acc_sum  = (tag_q.first ? '0 : acc_q) + (tag_q.neg ? -prod_ext : prod_ext);

  // Outcome of the decision state.
  always_comb begin
    dec_cont = 1'b0;
    dec_flip = 1'b0;
    rep_en   = 1'b0;
    rep_idx  = 2'd0;
    if (state_q == gse_pkg::ST_DECIDE) begin
      case (cnt_q)
        gse_pkg::CNT_TETRA: begin
          if (phase_q) begin
            if (dot_pos) begin
              rep_en  = 1'b1;
              rep_idx = 2'd2 - face_q;
            end else if (face_q == 2'd2) begin
              dec_cont = 1'b1;
            end
          end
        end
        gse_pkg::CNT_TRI: begin
          dec_flip = phase_q && dot_neg;
        end
        gse_pkg::CNT_LINE: begin
          dec_cont = !pass_q && t_zero;
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      gse_pkg::ST_IDLE: begin
        if (in_fire) begin
          if ((mode_i == gse_pkg::MODE_EVOLVE) && ((cnt_q == gse_pkg::CNT_TETRA) ||
              (cnt_q == gse_pkg::CNT_TRI) || (cnt_q == gse_pkg::CNT_LINE))) begin
            state_d = gse_pkg::ST_CROSS;
          end else begin
            state_d = gse_pkg::ST_DONE;
          end
        end
      end
      gse_pkg::ST_CROSS: begin
        if (step_q == 3'd5) state_d = gse_pkg::ST_DRAIN;
      end
      gse_pkg::ST_DOT: begin
        if (step_q == 3'd2) state_d = gse_pkg::ST_DRAIN;
      end
      gse_pkg::ST_DRAIN: begin
        state_d = gse_pkg::ST_DECIDE;
      end
      gse_pkg::ST_DECIDE: begin
        state_d = gse_pkg::ST_DONE;
        case (cnt_q)
          gse_pkg::CNT_TETRA: begin
            if (!phase_q) begin
              state_d = gse_pkg::ST_DOT;
            end else if (!dot_pos && (face_q != 2'd2)) begin
              state_d = gse_pkg::ST_CROSS;
            end
          end
          gse_pkg::CNT_TRI: begin
            if (!phase_q) state_d = gse_pkg::ST_DOT;
          end
          gse_pkg::CNT_LINE: begin
            if (!pass_q && !t_zero) state_d = gse_pkg::ST_CROSS;
          end
          default: begin
          end
        endcase
      end
      gse_pkg::ST_DONE: begin
        if (done_fire) state_d = gse_pkg::ST_IDLE;
      end
      default: begin
        state_d = gse_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= gse_pkg::ST_IDLE;
      step_q      <= '0;
      face_q      <= '0;
      pass_q      <= 1'b0;
      phase_q     <= 1'b0;
      tag_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      tag_q   <= tag_d;
      if (state_d != state_q) begin
        step_q <= '0;
      end else begin
        step_q <= step_q + 3'd1;
      end
      if (in_fire) begin
        face_q  <= '0;
        pass_q  <= 1'b0;
        phase_q <= 1'b0;
      end else if (state_q == gse_pkg::ST_DECIDE) begin
        if (state_d == gse_pkg::ST_DOT) begin
          phase_q <= 1'b1;
        end else if (state_d == gse_pkg::ST_CROSS) begin
          phase_q <= 1'b0;
          pass_q  <= 1'b1;
          face_q  <= face_q + 2'd1;
        end
      end
      if (done_fire) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Simplex storage and count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      for (int p = 0; p < gse_pkg::MAX_POINTS; p++) begin
        for (int i = 0; i < 3; i++) pts_q[p][i] <= '0;
      end
    end else if (in_fire && (mode_i == gse_pkg::MODE_CLEAR)) begin
      cnt_q <= '0;
      for (int p = 0; p < gse_pkg::MAX_POINTS; p++) begin
        for (int i = 0; i < 3; i++) pts_q[p][i] <= '0;
      end
    end else if (in_fire && (mode_i == gse_pkg::MODE_ADD) && (cnt_q < gse_pkg::CNT_TETRA)) begin
      cnt_q <= cnt_q + 3'd1;
      for (int i = 0; i < 3; i++) pts_q[cnt_q[1:0]][i] <= in_pt[i];
    end else if (rep_en) begin
      cnt_q <= gse_pkg::CNT_TRI;
      for (int i = 0; i < 3; i++) pts_q[rep_idx][i] <= pts_q[3][i];
    end
  end

  // Shared multiply-accumulate datapath and result staging.
  always_ff @(posedge clk_i) begin
    prod_q <= a_op * b_op;
    if (tag_q.vld) begin
      acc_q <= acc_sum;
      if (tag_q.wr) res_q[tag_q.comp] <= acc_sum;
    end
    // The line's first cross product stays put while the second overwrites res_q.
    if ((state_q == gse_pkg::ST_DECIDE) && (cnt_q == gse_pkg::CNT_LINE) && !pass_q) begin
      for (int i = 0; i < 3; i++) t_q[i] <= NW'(res_q[i]);
    end
    if (in_fire) begin
      p_acc_q  <= (mode_i == gse_pkg::MODE_ADD) && (cnt_q < gse_pkg::CNT_TETRA);
      p_cont_q <= 1'b0;
      for (int i = 0; i < 3; i++) begin
        if (mode_i == gse_pkg::MODE_EVOLVE) begin
          res_q[i] <= -AW'(pts_q[0][i]);
        end else begin
          res_q[i] <= '0;
        end
      end
    end else if (dec_cont) begin
      p_cont_q <= 1'b1;
      for (int i = 0; i < 3; i++) res_q[i] <= '0;
    end else if (dec_flip) begin
      for (int i = 0; i < 3; i++) res_q[i] <= -res_q[i];
    end
    if (done_fire) begin
      out_acc_q  <= p_acc_q;
      out_cont_q <= p_cont_q;
      out_cnt_q  <= cnt_q;
      for (int i = 0; i < 3; i++) out_dir_q[i] <= gse_pkg::DIR_BITS'(res_q[i]);
    end
  end

  assign out_valid_o       = out_valid_q;
  assign accepted_o        = out_acc_q;
  assign contains_origin_o = out_cont_q;
  assign dir_x_o           = out_dir_q[0];
  assign dir_y_o           = out_dir_q[1];
  assign dir_z_o           = out_dir_q[2];
  assign point_count_o     = out_cnt_q;

endmodule
